/* rtl/sobel_et_pkg.sv */
package sobel_et_pkg;

  // Field and register widths
  localparam int PIX_W  = 8;
  localparam int CFG_W  = 11;
  localparam int CFG_IW = 2;
  localparam int THR_W  = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd1024;
  localparam logic [THR_W-1:0] THRESH_RESET = 8'd128;

  // Input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Result codes
  localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;

  // Queue sizes
  localparam int OPQ_DEPTH  = 4;
  localparam int OUTQ_DEPTH = 4;
  localparam int OPQ_CW     = $clog2(OPQ_DEPTH + 1);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // Window update kinds handed from front to back
  typedef enum logic [1:0] {
    OP_SHIFT1,  // shift in column a
    OP_FILL3,   // load column a into all three slots
    OP_SHIFT2   // shift in column a, then column b
  } op_mode_t;

  // One window column: top, middle, bottom pixel
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  // Work for the back end. dbl: emit, then shift in a copy of the right
  // column and emit again (last pixel of a row).
  typedef struct packed {
    op_mode_t mode;
    logic     dbl;
    logic     emit;
    logic     frame_end;
    logic     run_end;
    col_t     col_a;
    col_t     col_b;
  } op_t;

  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic             frame_end;
    logic             run_end;
  } res_t;

  typedef enum logic {
    FR_TAKE,
    FR_SECOND
  } fr_state_t;

endpackage

/* rtl/sobel_et_fifo.sv */
module sobel_et_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  // Beat qualification
  assign do_pop  = pop && (count_r != '0);
  assign do_push = push && ((count_r != CNTW'(DEPTH)) || do_pop);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

endmodule

/* rtl/sobel_et_front.sv */
module sobel_et_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sobel_et_pkg::CFG_W-1:0]  cfg_width,
  input  logic [sobel_et_pkg::CFG_W-1:0]  cfg_height,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_command,
  input  logic [sobel_et_pkg::PIX_W-1:0]  in_pixel,
  input  logic [sobel_et_pkg::OPQ_CW-1:0] opq_count,
  output logic                            op_push,
  output sobel_et_pkg::op_t               op_data
);

  import sobel_et_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  // Read request carried from the issue stage to the assembly stage
  typedef struct packed {
    logic             is_flush;
    logic             row0;
    logic             use_older;
    op_mode_t         mode;
    logic             dbl;
    logic             emit;
    logic             frame_end;
    logic             run_end;
    logic [PIX_W-1:0] pixel;
    logic [CW-1:0]    addr;
  } req_t;

  fr_state_t        state_r, state_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic             seq_r, seq_nxt;
  logic [CW-1:0]    sec_addr_r, sec_addr_nxt;
  logic             sec_last_r, sec_last_nxt;
  logic             sec_older_r, sec_older_nxt;
  logic             s2_valid_r;
  req_t             s2_r;
  req_t             iss_req;
  logic             iss;

  logic [WW-1:0]    eff_w;
  logic [RW-1:0]    eff_h;
  logic [OPQ_CW:0]  q_used;
  logic             room, accept, pending, fast, slow_flush;
  logic             restart, plast, flast, fold;
  logic [RW-1:0]    rc;
  logic [CW-1:0]    cc0, pc, fc, fl, fr;
  logic [CW-1:0]    rd_a, rd_b;
  logic             nwe, owe;

  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] nrd_a_r, nrd_b_r, ord_a_r, ord_b_r, fwd_d_r;
  logic             fwd_a_r, fwd_b_r;
  logic [PIX_W-1:0] ma, mb, oa, ob, ta, tb;

  // Effective frame size, clamped to 1..MAX
  always_comb begin
    if (cfg_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg_width);
    end
    if (cfg_height == '0) begin
      eff_h = RW'(1);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(cfg_height);
    end
  end

  // Room in the op queue, counting the beat in the assembly stage
  assign q_used = {1'b0, opq_count} + (OPQ_CW+1)'(s2_valid_r);
  assign room   = q_used < (OPQ_CW+1)'(OPQ_DEPTH);
  assign in_full = (state_r == FR_SECOND) || !room;
  assign accept  = in_push && !in_full;

  // Pixel position: restart a frame once all rows are in
  assign restart = (row_r >= eff_h);
  assign rc      = restart ? '0 : row_r;
  assign cc0     = restart ? '0 : col_r;
  assign pc      = (WW'(cc0) >= eff_w) ? CW'(eff_w - WW'(1)) : cc0;
  assign plast   = (WW'(pc) == eff_w - WW'(1));

  // Flush position and its neighbor columns
  assign pending = (row_r >= eff_h);
  assign fc      = (WW'(col_r) >= eff_w) ? CW'(eff_w - WW'(1)) : col_r;
  assign flast   = (WW'(fc) == eff_w - WW'(1));
  assign fl      = (fc == '0) ? '0 : fc - CW'(1);
  assign fr      = flast ? fc : fc + CW'(1);
  assign fold    = (row_r > RW'(1));
  // window already holds columns c-1 and c from the previous flush
  assign fast    = seq_r && (WW'(col_r) < eff_w);
  assign slow_flush = accept && (in_command == CMD_FLUSH) && pending && !fast;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_TAKE: begin
        if (slow_flush) begin
          state_nxt = FR_SECOND;
        end
      end
      FR_SECOND: begin
        if (room) begin
          state_nxt = FR_TAKE;
        end
      end
      default: state_nxt = FR_TAKE;
    endcase
  end

  // Issue: classify the beat, address the line stores, advance the counters
  always_comb begin
    iss           = 1'b0;
    iss_req       = '0;
    rd_a          = '0;
    rd_b          = '0;
    nwe           = 1'b0;
    col_nxt       = col_r;
    row_nxt       = row_r;
    seq_nxt       = seq_r;
    sec_addr_nxt  = sec_addr_r;
    sec_last_nxt  = sec_last_r;
    sec_older_nxt = sec_older_r;
    case (state_r)
      FR_TAKE: begin
        if (accept && (in_command == CMD_PIXEL)) begin
          iss               = 1'b1;
          nwe               = 1'b1;
          rd_a              = pc;
          iss_req.row0      = (rc == '0);
          iss_req.use_older = (rc > RW'(1));
          iss_req.pixel     = in_pixel;
          iss_req.addr      = pc;
          iss_req.run_end   = 1'b1;
          if (pc == '0) begin
            iss_req.mode = OP_FILL3;
            iss_req.emit = plast && (rc != '0);
          end else begin
            iss_req.mode = OP_SHIFT1;
            iss_req.emit = (rc != '0);
            iss_req.dbl  = plast;
          end
          seq_nxt = 1'b0;
          if (plast) begin
            col_nxt = '0;
            row_nxt = rc + RW'(1);
          end else begin
            col_nxt = pc + CW'(1);
            row_nxt = rc;
          end
        end else if (accept && pending) begin
          iss               = 1'b1;
          iss_req.is_flush  = 1'b1;
          iss_req.use_older = fold;
          if (fast) begin
            rd_a              = fr;
            iss_req.mode      = OP_SHIFT1;
            iss_req.emit      = 1'b1;
            iss_req.frame_end = flast;
            iss_req.run_end   = 1'b1;
          end else begin
            // left and center now, right column from FR_SECOND once the op queue has room
            rd_a          = fl;
            rd_b          = fc;
            iss_req.mode  = OP_SHIFT2;
            sec_addr_nxt  = fr;
            sec_last_nxt  = flast;
            sec_older_nxt = fold;
          end
          if (flast) begin
            col_nxt = '0;
            row_nxt = '0;
            seq_nxt = 1'b0;
          end else begin
            col_nxt = fc + CW'(1);
            seq_nxt = 1'b1;
          end
        end
      end
      FR_SECOND: begin
        if (room) begin
          iss               = 1'b1;
          rd_a              = sec_addr_r;
          iss_req.is_flush  = 1'b1;
          iss_req.use_older = sec_older_r;
          iss_req.mode      = OP_SHIFT1;
          iss_req.emit      = 1'b1;
          iss_req.frame_end = sec_last_r;
          iss_req.run_end   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= FR_TAKE;
      col_r      <= '0;
      row_r      <= '0;
      seq_r      <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      seq_r      <= seq_nxt;
      s2_valid_r <= iss;
    end
  end

  always_ff @(posedge clk) begin
    sec_addr_r  <= sec_addr_nxt;
    sec_last_r  <= sec_last_nxt;
    sec_older_r <= sec_older_nxt;
    if (iss) begin
      s2_r <= iss_req;
    end
  end

  // Newer row store: pixel written at issue, read-first
  always_ff @(posedge clk) begin
    if (nwe) begin
      newer_mem[pc] <= in_pixel;
    end
    nrd_a_r <= newer_mem[rd_a];
    nrd_b_r <= newer_mem[rd_b];
  end

  // Older row store: gets the retired newer entry in the cycle after issue
  assign owe = s2_valid_r && !s2_r.is_flush && !s2_r.row0;

  always_ff @(posedge clk) begin
    if (owe) begin
      older_mem[s2_r.addr] <= nrd_a_r;
    end
    ord_a_r <= older_mem[rd_a];
    ord_b_r <= older_mem[rd_b];
  end

  // Bypass for a read that meets the late older-store write
  always_ff @(posedge clk) begin
    fwd_a_r <= owe && (s2_r.addr == rd_a);
    fwd_b_r <= owe && (s2_r.addr == rd_b);
    fwd_d_r <= nrd_a_r;
  end

  // Assemble window columns
  assign ma = nrd_a_r;
  assign mb = nrd_b_r;
  assign oa = fwd_a_r ? fwd_d_r : ord_a_r;
  assign ob = fwd_b_r ? fwd_d_r : ord_b_r;
  assign ta = s2_r.use_older ? oa : ma;
  assign tb = s2_r.use_older ? ob : mb;

  always_comb begin
    op_data           = '0;
    op_data.mode      = s2_r.mode;
    op_data.dbl       = s2_r.dbl;
    op_data.emit      = s2_r.emit;
    op_data.frame_end = s2_r.frame_end;
    op_data.run_end   = s2_r.run_end;
    if (s2_r.is_flush) begin
      // bottom edge replicated
      op_data.col_a = '{top: ta, mid: ma, bot: ma};
      op_data.col_b = '{top: tb, mid: mb, bot: mb};
    end else if (s2_r.row0) begin
      op_data.col_a = '{top: s2_r.pixel, mid: s2_r.pixel, bot: s2_r.pixel};
    end else begin
      op_data.col_a = '{top: ta, mid: ma, bot: s2_r.pixel};
    end
  end

  assign op_push = s2_valid_r;

endmodule

/* rtl/sobel_et_back.sv */
module sobel_et_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [sobel_et_pkg::THR_W-1:0]   thresh,
  input  logic                             op_empty,
  input  sobel_et_pkg::op_t                op_head,
  output logic                             op_pop,
  input  logic [sobel_et_pkg::OUTQ_CW-1:0] outq_count,
  output logic                             outq_push,
  output sobel_et_pkg::res_t               outq_data
);

  import sobel_et_pkg::*;

  // Window slots are column-major: slot 3*col + row, col 0 on the left
  logic [PIX_W-1:0]   win_r [9];
  logic [PIX_W-1:0]   win_nxt [9];
  logic               phase_r, phase_nxt;
  logic [OUTQ_CW:0]   used;
  logic               go, first_half, second_half;
  logic               emit_fe, emit_re;

  logic [9:0]         sx_rgt, sx_lft, sy_b, sy_t;
  logic signed [11:0] gx, gy;
  logic signed [11:0] gx_r, gy_r;
  logic               g_valid_r, g_fe_r, g_re_r;
  logic [9:0]         ax, ay;
  logic [19:0]        sqx_r, sqy_r;
  logic               sq_valid_r, sq_fe_r, sq_re_r;
  logic [20:0]        mag2;
  logic [15:0]        t2;
  logic [19:0]        lim_r;

  // Credit: every result in flight has a slot waiting in the output queue
  assign used = {1'b0, outq_count} + (OUTQ_CW+1)'(g_valid_r) + (OUTQ_CW+1)'(sq_valid_r);
  assign go   = !op_empty && (used < (OUTQ_CW+1)'(OUTQ_DEPTH));

  assign first_half  = op_head.dbl && !phase_r;
  assign second_half = op_head.dbl && phase_r;
  assign op_pop      = go && !first_half;
  assign phase_nxt   = (go && op_head.dbl) ? !phase_r : phase_r;
  assign emit_fe     = op_head.frame_end && !first_half;
  assign emit_re     = op_head.run_end && !first_half;

  // Window update
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_nxt[i] = win_r[i];
    end
    if (go) begin
      if (second_half) begin
        // replicate the right column
        for (int i = 0; i < 6; i++) begin
          win_nxt[i] = win_r[i+3];
        end
      end else begin
        case (op_head.mode)
          OP_SHIFT1: begin
            for (int i = 0; i < 6; i++) begin
              win_nxt[i] = win_r[i+3];
            end
            win_nxt[6] = op_head.col_a.top;
            win_nxt[7] = op_head.col_a.mid;
            win_nxt[8] = op_head.col_a.bot;
          end
          OP_FILL3: begin
            for (int i = 0; i < 3; i++) begin
              win_nxt[3*i]   = op_head.col_a.top;
              win_nxt[3*i+1] = op_head.col_a.mid;
              win_nxt[3*i+2] = op_head.col_a.bot;
            end
          end
          OP_SHIFT2: begin
            win_nxt[0] = win_r[6];
            win_nxt[1] = win_r[7];
            win_nxt[2] = win_r[8];
            win_nxt[3] = op_head.col_a.top;
            win_nxt[4] = op_head.col_a.mid;
            win_nxt[5] = op_head.col_a.bot;
            win_nxt[6] = op_head.col_b.top;
            win_nxt[7] = op_head.col_b.mid;
            win_nxt[8] = op_head.col_b.bot;
          end
          default: ;
        endcase
      end
    end
  end

  // Sobel gradients on the updated window
  assign sx_rgt = 10'(win_nxt[6]) + {1'b0, win_nxt[7], 1'b0} + 10'(win_nxt[8]);
  assign sx_lft = 10'(win_nxt[0]) + {1'b0, win_nxt[1], 1'b0} + 10'(win_nxt[2]);
  assign sy_b   = 10'(win_nxt[2]) + {1'b0, win_nxt[5], 1'b0} + 10'(win_nxt[8]);
  assign sy_t   = 10'(win_nxt[0]) + {1'b0, win_nxt[3], 1'b0} + 10'(win_nxt[6]);
  assign gx     = 12'(sx_rgt) - 12'(sx_lft);
  assign gy     = 12'(sy_b) - 12'(sy_t);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
      phase_r    <= 1'b0;
      g_valid_r  <= 1'b0;
      sq_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= win_nxt[i];
      end
      phase_r    <= phase_nxt;
      g_valid_r  <= go && op_head.emit;
      sq_valid_r <= g_valid_r;
    end
  end

  // Magnitudes and squares
  assign ax = gx_r[11] ? 10'(-gx_r) : 10'(gx_r);
  assign ay = gy_r[11] ? 10'(-gy_r) : 10'(gy_r);

  always_ff @(posedge clk) begin
    gx_r    <= gx;
    gy_r    <= gy;
    g_fe_r  <= emit_fe;
    g_re_r  <= emit_re;
    sqx_r   <= ax * ax;
    sqy_r   <= ay * ay;
    sq_fe_r <= g_fe_r;
    sq_re_r <= g_re_r;
  end

  // Threshold limit 16*T^2, kept registered
  assign t2 = thresh * thresh;

  always_ff @(posedge clk) begin
    lim_r <= {t2, 4'b0000};
  end

  // Compare and hand to the output queue
  assign mag2 = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_comb begin
    outq_data.edge_value = (mag2 >= {1'b0, lim_r}) ? EDGE_ON : EDGE_OFF;
    outq_data.frame_end  = sq_fe_r;
    outq_data.run_end    = sq_re_r;
  end

  assign outq_push = sq_valid_r;

endmodule

/* rtl/sobel_edge_threshold_stream.sv */
// Channel   Handshake          Payload                                  Beat taken when
// in        in_push / in_full  in_command, in_pixel                     in_push && !in_full
// out       out_empty / out_pop out_edge_value, out_frame_end, out_run_end out_pop && !out_empty
// cfg       cfg_we             cfg_index, cfg_data                      cfg_we
//
// One input beat per cycle while in_full is low. The last pixel of a row yields two
// results and holds the gradient unit for both. A flush that does not follow a flush
// of the previous column is issued from FR_TAKE and then from FR_SECOND, as each line
// store reads two columns a cycle. A full result queue stalls the back, then the front.
// rst_n is synchronous; the line stores are not cleared, so no clearing pass.
// in_full rises when the op queue is short of room or while a flush is in FR_SECOND.
module sobel_edge_threshold_stream #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_command,
  input  logic [sobel_et_pkg::PIX_W-1:0]  in_pixel,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [sobel_et_pkg::PIX_W-1:0]  out_edge_value,
  output logic                            out_frame_end,
  output logic                            out_run_end,
  input  logic                            cfg_we,
  input  logic [sobel_et_pkg::CFG_IW-1:0] cfg_index,
  input  logic [sobel_et_pkg::CFG_W-1:0]  cfg_data
);

  import sobel_et_pkg::*;

  logic [CFG_W-1:0]    width_r, width_nxt;
  logic [CFG_W-1:0]    height_r, height_nxt;
  logic [THR_W-1:0]    thresh_r, thresh_nxt;

  logic                op_push, op_pop, opq_empty;
  op_t                 op_data, op_head;
  logic [$bits(op_t)-1:0] op_head_bits;
  logic [OPQ_CW-1:0]   opq_count;

  logic                outq_push;
  res_t                outq_data, out_res;
  logic [$bits(res_t)-1:0] out_res_bits;
  logic [OUTQ_CW-1:0]  outq_count;

  // Configuration registers
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    thresh_nxt = thresh_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:    width_nxt  = cfg_data;
        CFG_IMAGE_HEIGHT:   height_nxt = cfg_data;
        CFG_EDGE_THRESHOLD: thresh_nxt = cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      thresh_r <= THRESH_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      thresh_r <= thresh_nxt;
    end
  end

  // Front: counters, line stores, classification
  sobel_et_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_command (in_command),
    .in_pixel   (in_pixel),
    .opq_count  (opq_count),
    .op_push    (op_push),
    .op_data    (op_data)
  );

  // Op queue between front and back
  sobel_et_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (OPQ_DEPTH)
  ) u_opq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (op_push),
    .push_data (op_data),
    .pop       (op_pop),
    .pop_data  (op_head_bits),
    .empty     (opq_empty),
    .count     (opq_count)
  );

  assign op_head = op_t'(op_head_bits);

  // Back: window, gradients, threshold
  sobel_et_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .thresh     (thresh_r),
    .op_empty   (opq_empty),
    .op_head    (op_head),
    .op_pop     (op_pop),
    .outq_count (outq_count),
    .outq_push  (outq_push),
    .outq_data  (outq_data)
  );

  // Result queue
  sobel_et_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (outq_push),
    .push_data (outq_data),
    .pop       (out_pop),
    .pop_data  (out_res_bits),
    .empty     (out_empty),
    .count     (outq_count)
  );

  assign out_res        = res_t'(out_res_bits);
  assign out_edge_value = out_res.edge_value;
  assign out_frame_end  = out_res.frame_end;
  assign out_run_end    = out_res.run_end;

  // Front never pushes into a full op queue
  a_opq_room: assert property (@(posedge clk) disable iff (!rst_n)
    op_push |-> (opq_count < OPQ_DEPTH) || op_pop)
    else $error("op queue overrun");

  // Result credit keeps the output queue from overflowing
  a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
    outq_push |-> (outq_count < OUTQ_DEPTH) || (out_pop && !out_empty))
    else $error("result queue overrun");

  // The frame's last result always closes its beat's run
  a_frame_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_end) |-> out_run_end)
    else $error("frame end without run end");

endmodule
